/* rtl/ssqb_pkg.sv */
// ----------------------------------------------------------------------------
// ssqb_pkg
// shared types and constants of the stacked string queue buffer
// ----------------------------------------------------------------------------
`default_nettype none

package ssqb_pkg;

  localparam int unsigned ADDR_BITS_DEF = 16;
  localparam int unsigned OP_W          = 2;
  localparam int unsigned BYTE_W        = 8;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_PUSH   = 2'd2,
    OP_POP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REMOVE,
    ST_PUSH,
    ST_POP
  } state_e;

endpackage

`default_nettype wire

/* rtl/ssqb_ram.sv */
// ----------------------------------------------------------------------------
// ssqb_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module ssqb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/stacked_string_queue_buffer_top.sv */
// ----------------------------------------------------------------------------
// stacked_string_queue_buffer_top
// stack of queues of zero-terminated strings in one byte-wide memory
// ----------------------------------------------------------------------------
// Usage:
//   An item (operation_i, in_byte_i) is taken at a rising edge with start
//   high and busy low. Its result appears on the result ports for exactly
//   one cycle with done_o high; the receiver cannot stall it.
//   Work before done_o, with F = 3 * ceil(ADDR_BITS / 8) frame bytes
//   (F = 6 at 16 bits):
//     add, and any refused or empty-stack operation: result registered at once
//     remove: one memory read, then the result
//     push: F frame bytes written, one frame byte per cycle
//     pop: F frame bytes read, one frame byte per cycle, plus read latency
//   The single memory port forces this order. A new item may be taken in
//   the cycle in which done_o shows the previous result.
//   Reset clears the pointers (head and tail at F, no saved frame); the
//   memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module stacked_string_queue_buffer_top #(
  parameter int unsigned ADDR_BITS = ssqb_pkg::ADDR_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [ssqb_pkg::OP_W-1:0]   operation_i,
  input  wire logic [ssqb_pkg::BYTE_W-1:0] in_byte_i,
  output logic                             done_o,
  output logic      [ssqb_pkg::BYTE_W-1:0] out_byte_o,
  output logic                             string_end_o,
  output logic                             found_empty_o,
  output logic                             queue_empty_o,
  output logic                             overflow_o
);

  import ssqb_pkg::*;

  localparam int unsigned AW          = ADDR_BITS;
  localparam int unsigned PTR_BYTES   = (ADDR_BITS + 7) / 8;
  localparam int unsigned FRAME_BYTES = 3 * PTR_BYTES;
  localparam int unsigned PW          = 8 * PTR_BYTES;
  localparam int unsigned FW          = 8 * FRAME_BYTES;
  localparam int unsigned CNT_W       = $clog2(FRAME_BYTES + 1);

  localparam logic [AW-1:0]    ADDR_LAST  = {AW{1'b1}};
  localparam logic [AW-1:0]    PUSH_LIMIT = {AW{1'b1}} - AW'(15);
  localparam logic [AW-1:0]    FRAME_LEN  = AW'(FRAME_BYTES);
  localparam logic [CNT_W-1:0] CNT_WLAST  = CNT_W'(FRAME_BYTES - 1);
  localparam logic [CNT_W-1:0] CNT_RLAST  = CNT_W'(FRAME_BYTES);

  state_e state_q, state_d;

  logic [AW-1:0]     head_q, head_d;
  logic [AW-1:0]     tail_q, tail_d;
  logic [AW-1:0]     top_q, top_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [FW-1:0]     frame_q, frame_d;
  logic [FW-1:0]     frame_val;

  logic              done_q, done_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  logic              string_end_q, string_end_d;
  logic              found_empty_q, found_empty_d;
  logic              queue_empty_q, queue_empty_d;
  logic              overflow_q, overflow_d;

  logic              mem_we;
  logic [AW-1:0]     mem_addr;
  logic [BYTE_W-1:0] mem_wdata;
  logic [BYTE_W-1:0] mem_rdata;

  logic              accept;

  assign accept    = start && (state_q == ST_IDLE);
  assign frame_val = {PW'(tail_q), PW'(head_q), PW'(top_q)};

  ssqb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (2 ** ADDR_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (operation_i)
            OP_REMOVE: if (head_q < tail_q)    state_d = ST_REMOVE;
            OP_PUSH:   if (tail_q < PUSH_LIMIT) state_d = ST_PUSH;
            OP_POP:    if (top_q != '0)        state_d = ST_POP;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_REMOVE: state_d = ST_IDLE;
      ST_PUSH:   if (cnt_q == CNT_WLAST) state_d = ST_IDLE;
      ST_POP:    if (cnt_q == CNT_RLAST) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath, memory access and results
  always_comb begin
    head_d        = head_q;
    tail_d        = tail_q;
    top_d         = top_q;
    cnt_d         = cnt_q;
    frame_d       = frame_q;
    done_d        = 1'b0;
    out_byte_d    = out_byte_q;
    string_end_d  = string_end_q;
    found_empty_d = found_empty_q;
    queue_empty_d = queue_empty_q;
    overflow_d    = overflow_q;
    mem_we        = 1'b0;
    mem_addr      = head_q;
    mem_wdata     = in_byte_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          done_d        = 1'b1;
          out_byte_d    = '0;
          string_end_d  = 1'b0;
          found_empty_d = 1'b0;
          overflow_d    = 1'b0;
          cnt_d         = '0;
          case (operation_i)
            OP_ADD: begin
              mem_addr = tail_q;
              if (tail_q == ADDR_LAST) begin
                overflow_d = 1'b1;
              end else begin
                mem_we = 1'b1;
                tail_d = tail_q + AW'(1);
              end
            end
            OP_REMOVE: begin
              if (head_q >= tail_q) begin
                string_end_d  = 1'b1;
                found_empty_d = 1'b1;
              end else begin
                done_d = 1'b0;
              end
            end
            OP_PUSH: begin
              if (tail_q >= PUSH_LIMIT) begin
                overflow_d = 1'b1;
              end else begin
                done_d = 1'b0;
              end
            end
            OP_POP: begin
              if (top_q != '0) begin
                done_d = 1'b0;
              end
            end
            default: done_d = 1'b1;
          endcase
          queue_empty_d = (head_q >= tail_d);
        end
      end
      ST_REMOVE: begin
        done_d        = 1'b1;
        out_byte_d    = mem_rdata;
        string_end_d  = (mem_rdata == '0);
        head_d        = head_q + AW'(1);
        queue_empty_d = (head_d >= tail_q);
      end
      ST_PUSH: begin
        mem_we    = 1'b1;
        mem_addr  = tail_q + AW'(cnt_q);
        mem_wdata = frame_val[{cnt_q, 3'b000} +: 8];
        cnt_d     = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_WLAST) begin
          top_d         = tail_q;
          head_d        = tail_q + FRAME_LEN;
          tail_d        = tail_q + FRAME_LEN;
          done_d        = 1'b1;
          queue_empty_d = 1'b1;
        end
      end
      ST_POP: begin
        mem_addr = top_q + AW'(cnt_q);
        cnt_d    = cnt_q + CNT_W'(1);
        if (cnt_q != '0) begin
          frame_d = {mem_rdata, frame_q[FW-1:8]};
        end
        if (cnt_q == CNT_RLAST) begin
          top_d         = frame_d[AW-1:0];
          head_d        = frame_d[PW +: AW];
          tail_d        = frame_d[2*PW +: AW];
          done_d        = 1'b1;
          queue_empty_d = (head_d >= tail_d);
        end
      end
      default: done_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= FRAME_LEN;
      tail_q  <= FRAME_LEN;
      top_q   <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      top_q   <= top_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q       <= frame_d;
    out_byte_q    <= out_byte_d;
    string_end_q  <= string_end_d;
    found_empty_q <= found_empty_d;
    queue_empty_q <= queue_empty_d;
    overflow_q    <= overflow_d;
  end

  assign busy          = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign out_byte_o    = out_byte_q;
  assign string_end_o  = string_end_q;
  assign found_empty_o = found_empty_q;
  assign queue_empty_o = queue_empty_q;
  assign overflow_o    = overflow_q;

endmodule

`default_nettype wire

/* rtl/ssqb_checker.sv */
// ----------------------------------------------------------------------------
// ssqb_checker
// port-level checks of the stacked string queue buffer, bound to the top
// ----------------------------------------------------------------------------
`default_nettype none

module ssqb_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        done_o,
  input wire logic [ssqb_pkg::BYTE_W-1:0] out_byte_o,
  input wire logic                        string_end_o,
  input wire logic                        found_empty_o,
  input wire logic                        queue_empty_o,
  input wire logic                        overflow_o
);

  // an accepted item either finishes at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (done_o || busy))
    else $error("accepted item neither done nor busy");

  // leaving busy always delivers a result
  a_busy_end_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result");

  // an empty remove reports a terminator, zero byte and empty queue
  a_empty_remove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && found_empty_o) |->
      (string_end_o && queue_empty_o && (out_byte_o == '0) && !overflow_o))
    else $error("inconsistent empty remove result");

  // overflow belongs to add and push only
  a_overflow_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && overflow_o) |-> (!string_end_o && (out_byte_o == '0)))
    else $error("overflow mixed with remove result");

  // a nonzero byte never ends a string
  a_byte_not_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (out_byte_o != '0)) |-> !string_end_o)
    else $error("nonzero byte flagged as string end");

endmodule

bind stacked_string_queue_buffer_top ssqb_checker u_ssqb_checker (.*);

`default_nettype wire
